>>> design/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared widths and the result bundle of the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  // Width of the candidate number (4 to 64).
  localparam int unsigned NUM_WIDTH = 32;

  // Bits of a counter that steps through one quotient bit per cycle.
  localparam int unsigned CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

  // Stream data widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((NUM_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // Divider result, valid in the cycle that done is high.
  typedef struct packed {
    logic                 done;
    logic [NUM_WIDTH-1:0] quotient;
    logic [NUM_WIDTH-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

>>> design/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// Trial division prime test unit
// Tests one unsigned candidate per item for primality using 6k-1 / 6k+1 trial
// divisors and a shared multi-cycle divider.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) takes one candidate per item. The result channel
//   (out_*) returns exactly one item per candidate, carrying is_prime.
//   Zero and one yield 0, two and three yield 1, and even candidates are
//   settled by their low bit. Every other candidate goes through one shared
//   restoring divider that produces one quotient bit per cycle. The
//   candidate is first divided by 3, then by each pair 6k-1 and 6k+1; the
//   division by 6k-1 also gives the quotient that ends the search once 6k-1
//   exceeds candidate / (6k-1). A prime near 2^32 needs about 2 * 10900
//   divisions; composites stop at the first exact division.
//   The unit holds in_tready low while a candidate is being tested and
//   raises it again once the result sits in the output register, so the
//   next candidate can be taken while that result still waits.
//   If the receiver stalls with out_tvalid high, a finished test waits in its
//   final state until the output register frees up.
//   Synchronous reset (rst_n low) drops any test in progress and any pending
//   result; the unit then comes up idle and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [tdp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [NUM_WIDTH-1:0] candidate
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [tdp_pkg::OUT_TDATA_W-1:0] out_tdata   // [0] is_prime, rest zero
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD3,
    ST_LO,
    ST_HI,
    ST_RESULT
  } state_t;

  localparam int unsigned W = tdp_pkg::NUM_WIDTH;

  state_t          state_r, state_nxt;
  logic [W-1:0]    num_r, num_nxt;       // candidate under test
  logic [W-1:0]    lo_r, lo_nxt;         // current 6k-1 divisor
  logic [W-1:0]    den_r, den_nxt;       // divisor handed to the divider
  logic            div_start_r, div_start_nxt;
  logic            verdict_r, verdict_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_bit_r, out_bit_nxt;
  logic [W-1:0]    cand;
  tdp_pkg::div_res_t div_res;

  assign cand = in_tdata[W-1:0];

  tdp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (num_r),
    .divisor  (den_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    lo_nxt        = lo_r;
    den_nxt       = den_r;
    div_start_nxt = 1'b0;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          num_nxt = cand;
          if (cand < W'(2)) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else if (cand == W'(2) || cand == W'(3)) begin
            verdict_nxt = 1'b1;
            state_nxt   = ST_RESULT;
          end else if (!cand[0]) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else begin
            den_nxt       = W'(3);
            div_start_nxt = 1'b1;
            state_nxt     = ST_MOD3;
          end
        end
      end
      ST_MOD3: begin
        if (div_res.done) begin
          if (div_res.remainder == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else begin
            lo_nxt        = W'(5);
            den_nxt       = W'(5);
            div_start_nxt = 1'b1;
            state_nxt     = ST_LO;
          end
        end
      end
      ST_LO: begin
        // The quotient of candidate / lo bounds the search.
        if (div_res.done) begin
          if (lo_r > div_res.quotient) begin
            verdict_nxt = 1'b1;
            state_nxt   = ST_RESULT;
          end else if (div_res.remainder == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else begin
            den_nxt       = lo_r + W'(2);
            div_start_nxt = 1'b1;
            state_nxt     = ST_HI;
          end
        end
      end
      ST_HI: begin
        if (div_res.done) begin
          if (div_res.remainder == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else begin
            lo_nxt        = lo_r + W'(6);
            den_nxt       = lo_r + W'(6);
            div_start_nxt = 1'b1;
            state_nxt     = ST_LO;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = verdict_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r     <= num_nxt;
    lo_r      <= lo_nxt;
    den_r     <= den_nxt;
    verdict_r <= verdict_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(tdp_pkg::OUT_TDATA_W - 1)'(0), out_bit_r};

endmodule

`default_nettype wire

>>> design/tdp_divider.sv
// ----------------------------------------------------------------------------
// Trial division prime test divider
// Restoring divider, one quotient bit per cycle, shared by all trial divisors.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tdp_pkg::NUM_WIDTH-1:0] dividend,
  input  wire logic [tdp_pkg::NUM_WIDTH-1:0] divisor,
  output tdp_pkg::div_res_t                  res
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [tdp_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [tdp_pkg::NUM_WIDTH-1:0]   rem_r, rem_nxt;
  logic [tdp_pkg::NUM_WIDTH-1:0]   quo_r, quo_nxt;
  logic [tdp_pkg::NUM_WIDTH-1:0]   den_r, den_nxt;
  logic [tdp_pkg::NUM_WIDTH:0]     trial;
  logic [tdp_pkg::NUM_WIDTH:0]     diff;
  logic                            fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign trial = {rem_r, quo_r[tdp_pkg::NUM_WIDTH-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tdp_pkg::CNT_W'(tdp_pkg::NUM_WIDTH - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[tdp_pkg::NUM_WIDTH-1:0] : trial[tdp_pkg::NUM_WIDTH-1:0];
      quo_nxt = {quo_r[tdp_pkg::NUM_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

`default_nettype wire
